/* src/lfru_replica_victim_selector_macros.svh */
// Assertion macros shared by the victim selector RTL.
`ifndef LFRU_REPLICA_VICTIM_SELECTOR_MACROS_SVH
`define LFRU_REPLICA_VICTIM_SELECTOR_MACROS_SVH

// Check that holds only while the block is out of reset.
`define LFRU_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define LFRU_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lfru_pkg.sv */
// Shared constants, codes and types for the LFRU victim selector.
package lfru_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int FILE_W  = 10;
  localparam int SRV_W   = 4;
  localparam int CNT_W   = 32;
  localparam int TIME_W  = 40;
  localparam int PROD_W  = 2 * TIME_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(60000000);
  localparam logic [NUM_W-1:0]  WEIGHT_BOUND = NUM_W'(64'd1000000000000);
  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

  typedef enum logic [1:0] {
    MODE_ACCESS = 2'd0,
    MODE_RESET  = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_ADD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_MATCH  = 2'd1,
    ST_NO_VICTIM = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  // Start request to the shared arithmetic unit.
  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_req_t;

  // Write request to the placement table.
  typedef struct packed {
    logic              we_info;
    logic              we_cnt;
    logic              we_last;
    logic [IDX_W-1:0]  addr;
    logic [FILE_W-1:0] file;
    logic [SRV_W-1:0]  server;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] last;
  } tbl_wr_t;

endpackage

/* src/lfru_alu.sv */
// Shared bit-serial multiplier and restoring divider.
module lfru_alu (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfru_pkg::alu_req_t             req,
  input  logic [lfru_pkg::NUM_W-1:0]     a_i,
  input  logic [lfru_pkg::TIME_W-1:0]    d_i,
  output logic                           done,
  output logic [lfru_pkg::NUM_W-1:0]     res
);

  logic                            run_r;
  logic                            done_r;
  lfru_pkg::alu_op_t               op_r;
  logic [lfru_pkg::STEP_W-1:0]     cnt_r;
  logic [lfru_pkg::TIME_W:0]       hi_r;
  logic [lfru_pkg::NUM_W-1:0]      lo_r;
  logic [lfru_pkg::TIME_W-1:0]     d_r;

  logic [lfru_pkg::TIME_W:0]       sum;
  logic [lfru_pkg::TIME_W:0]       rem_sh;
  logic [lfru_pkg::TIME_W+1:0]     diff;
  logic [lfru_pkg::TIME_W:0]       hi_nxt;
  logic [lfru_pkg::NUM_W-1:0]      lo_nxt;

  // One multiply or divide step per cycle.
  always_comb begin
    sum    = {1'b0, hi_r[lfru_pkg::TIME_W-1:0]} + (lo_r[0] ? {1'b0, d_r} : '0);
    rem_sh = {hi_r[lfru_pkg::TIME_W-1:0], lo_r[lfru_pkg::NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, d_r};
    unique case (op_r)
      lfru_pkg::ALU_MUL: begin
        hi_nxt = {1'b0, sum[lfru_pkg::TIME_W:1]};
        lo_nxt = {{(lfru_pkg::NUM_W-lfru_pkg::TIME_W){1'b0}}, sum[0],
                  lo_r[lfru_pkg::TIME_W-1:1]};
      end
      lfru_pkg::ALU_DIV: begin
        hi_nxt = diff[lfru_pkg::TIME_W+1] ? rem_sh : diff[lfru_pkg::TIME_W:0];
        lo_nxt = {lo_r[lfru_pkg::NUM_W-2:0], ~diff[lfru_pkg::TIME_W+1]};
      end
      default: begin
        hi_nxt = hi_r;
        lo_nxt = lo_r;
      end
    endcase
  end

  // Step counter and operand registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= lfru_pkg::ALU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        op_r  <= req.op;
        d_r   <= d_i;
        hi_r  <= '0;
        lo_r  <= a_i;
        cnt_r <= (req.op == lfru_pkg::ALU_MUL) ? lfru_pkg::STEP_W'(lfru_pkg::TIME_W)
                                               : lfru_pkg::STEP_W'(lfru_pkg::NUM_W);
      end else if (run_r) begin
        hi_r  <= hi_nxt;
        lo_r  <= lo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == lfru_pkg::STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = (op_r == lfru_pkg::ALU_MUL) ?
                {1'b0, hi_r[lfru_pkg::TIME_W-1:0], lo_r[lfru_pkg::TIME_W-1:0]} : lo_r;

endmodule

/* src/lfru_table.sv */
// Placement table: file, server, count and last access time per entry.
module lfru_table (
  input  logic                          clk,
  input  lfru_pkg::tbl_wr_t             wr,
  input  logic [lfru_pkg::IDX_W-1:0]    rd_addr,
  output logic [lfru_pkg::FILE_W-1:0]   rd_file,
  output logic [lfru_pkg::SRV_W-1:0]    rd_server,
  output logic [lfru_pkg::CNT_W-1:0]    rd_cnt,
  output logic [lfru_pkg::TIME_W-1:0]   rd_last
);

  logic [lfru_pkg::FILE_W+lfru_pkg::SRV_W-1:0] info_mem [lfru_pkg::TABLE_ENTRIES];
  logic [lfru_pkg::CNT_W-1:0]                  cnt_mem  [lfru_pkg::TABLE_ENTRIES];
  logic [lfru_pkg::TIME_W-1:0]                 last_mem [lfru_pkg::TABLE_ENTRIES];

  // Field-wise writes at one address.
  always_ff @(posedge clk) begin
    if (wr.we_info) info_mem[wr.addr] <= {wr.file, wr.server};
    if (wr.we_cnt)  cnt_mem[wr.addr]  <= wr.cnt;
    if (wr.we_last) last_mem[wr.addr] <= wr.last;
  end

  // Registered read at one address.
  always_ff @(posedge clk) begin
    {rd_file, rd_server} <= info_mem[rd_addr];
    rd_cnt               <= cnt_mem[rd_addr];
    rd_last              <= last_mem[rd_addr];
  end

endmodule

/* src/lfru_replica_victim_selector.sv */
// Top level of the LFRU victim selector: sequencer, state and ports.
//
//   Channel   Handshake            Payload
//   request   start / busy         in_mode, in_file_id, in_server_id, in_now
//   result    out_valid (strobe)   out_status, out_victim_file
//   config    cfg_we               cfg_wdata (period length)
//
// Access searches the placements until the file is found on the server. Period
// reset sets the count of each of the N placements to one. Add writes one entry.
// Select weighs each of the M placements that belong to the server; the bit-serial
// unit does one bit per cycle for two 81-step divides and a 40-step multiply.
// Reset is synchronous on rst_n and empties the table at once through the
// fill count. The result strobe lasts one cycle and cannot be stalled.
module lfru_replica_victim_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [lfru_pkg::FILE_W-1:0]   in_file_id,
  input  logic [lfru_pkg::SRV_W-1:0]    in_server_id,
  input  logic [lfru_pkg::TIME_W-1:0]   in_now,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [lfru_pkg::FILE_W-1:0]   out_victim_file,
  input  logic                          cfg_we,
  input  logic [lfru_pkg::TIME_W-1:0]   cfg_wdata
);

  `include "lfru_replica_victim_selector_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHK, S_TT, S_FREQ, S_REC, S_WDIV, S_CLR
  } state_t;

  state_t                         state_r;
  lfru_pkg::mode_t                mode_r;
  logic [lfru_pkg::FILE_W-1:0]    file_r;
  logic [lfru_pkg::SRV_W-1:0]     srv_r;
  logic [lfru_pkg::TIME_W-1:0]    now_r;
  logic [lfru_pkg::USED_W-1:0]    idx_r;
  logic [lfru_pkg::USED_W-1:0]    used_r;
  logic [lfru_pkg::TIME_W-1:0]    pstart_r;
  logic [lfru_pkg::TIME_W-1:0]    period_r;
  logic [lfru_pkg::TIME_W-1:0]    t_r;
  logic [lfru_pkg::PROD_W-1:0]    tt_r;
  logic [lfru_pkg::NUM_W-1:0]     freq_r;
  logic                           neg_r;
  logic                           best_neg_r;
  logic [lfru_pkg::NUM_W-1:0]     best_mag_r;
  logic                           found_r;
  logic [lfru_pkg::FILE_W-1:0]    victim_r;
  logic                           out_valid_r;
  lfru_pkg::status_t              out_status_r;
  logic [lfru_pkg::FILE_W-1:0]    out_victim_r;
  lfru_pkg::alu_req_t             alu_req_r;
  logic [lfru_pkg::NUM_W-1:0]     alu_a_r;
  logic [lfru_pkg::TIME_W-1:0]    alu_d_r;

  logic                           alu_done;
  logic [lfru_pkg::NUM_W-1:0]     alu_res;
  lfru_pkg::tbl_wr_t              tbl_wr;
  logic [lfru_pkg::FILE_W-1:0]    rd_file;
  logic [lfru_pkg::SRV_W-1:0]     rd_server;
  logic [lfru_pkg::CNT_W-1:0]     rd_cnt;
  logic [lfru_pkg::TIME_W-1:0]    rd_last;

  logic [lfru_pkg::TIME_W-1:0]    p_eff;
  logic [lfru_pkg::TIME_W-1:0]    t_in;
  logic [lfru_pkg::TIME_W-1:0]    r_val;
  logic [lfru_pkg::TIME_W-1:0]    pt_diff;
  logic [lfru_pkg::CNT_W-1:0]     c_eff;
  logic                           p_ge_t;
  logic [lfru_pkg::NUM_W-1:0]     num_val;
  logic                           num_neg;
  logic                           w_neg;
  logic                           w_less;
  logic                           hit;
  logic                           scan_end;

  lfru_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req_r),
    .a_i   (alu_a_r),
    .d_i   (alu_d_r),
    .done  (alu_done),
    .res   (alu_res)
  );

  lfru_table u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_addr   (idx_r[lfru_pkg::IDX_W-1:0]),
    .rd_file   (rd_file),
    .rd_server (rd_server),
    .rd_cnt    (rd_cnt),
    .rd_last   (rd_last)
  );

  // Weight terms for the entry under the read port.
  always_comb begin
    p_eff    = (period_r == '0) ? lfru_pkg::TIME_W'(1) : period_r;
    t_in     = (in_now >= pstart_r) ? in_now - pstart_r : '0;
    r_val    = (now_r >= rd_last) ? now_r - rd_last : '0;
    p_ge_t   = (p_eff >= t_r);
    pt_diff  = p_ge_t ? p_eff - t_r : t_r - p_eff;
    c_eff    = (rd_cnt == '0) ? lfru_pkg::CNT_W'(1) : rd_cnt;
    hit      = (rd_file == file_r) && (rd_server == srv_r);
    scan_end = (idx_r == used_r);
  end

  // Signed numerator from the recency product and the frequency quotient.
  always_comb begin
    if (p_ge_t) begin
      num_val = alu_res + freq_r;
      num_neg = 1'b0;
    end else if (freq_r < alu_res) begin
      num_val = alu_res - freq_r;
      num_neg = 1'b1;
    end else begin
      num_val = freq_r - alu_res;
      num_neg = 1'b0;
    end
  end

  // Compare the finished weight with the best so far.
  always_comb begin
    w_neg = neg_r && (alu_res != '0);
    if (w_neg != best_neg_r) w_less = w_neg;
    else if (w_neg)          w_less = (best_mag_r < alu_res);
    else                     w_less = (alu_res < best_mag_r);
  end

  // Table writes for access, period reset and add.
  always_comb begin
    tbl_wr         = '0;
    tbl_wr.addr    = idx_r[lfru_pkg::IDX_W-1:0];
    tbl_wr.file    = file_r;
    tbl_wr.server  = srv_r;
    tbl_wr.last    = now_r;
    tbl_wr.cnt     = lfru_pkg::CNT_W'(1);
    unique case (state_r)
      S_CHK: begin
        if (mode_r == lfru_pkg::MODE_ACCESS && hit) begin
          tbl_wr.we_cnt  = 1'b1;
          tbl_wr.we_last = 1'b1;
          tbl_wr.cnt     = (rd_cnt == lfru_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
        end
      end
      S_CLR: begin
        tbl_wr.we_cnt = !scan_end;
      end
      S_IDLE, S_SCAN, S_TT, S_FREQ, S_REC, S_WDIV: begin
        // A full table takes no new placement.
        if (state_r == S_SCAN && mode_r == lfru_pkg::MODE_ADD &&
            used_r != lfru_pkg::USED_W'(lfru_pkg::TABLE_ENTRIES)) begin
          tbl_wr.addr    = used_r[lfru_pkg::IDX_W-1:0];
          tbl_wr.we_info = 1'b1;
          tbl_wr.we_cnt  = 1'b1;
          tbl_wr.we_last = 1'b1;
        end
      end
      default: tbl_wr = '0;
    endcase
  end

  // Sequencer with its registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pstart_r    <= '0;
      period_r    <= lfru_pkg::PERIOD_RESET;
      out_valid_r <= 1'b0;
      alu_req_r   <= '0;
      mode_r      <= lfru_pkg::MODE_ACCESS;
      out_status_r <= lfru_pkg::ST_DONE;
      out_victim_r <= '0;
    end else begin
      out_valid_r   <= 1'b0;
      alu_req_r.go  <= 1'b0;
      if (cfg_we) period_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r     <= lfru_pkg::mode_t'(in_mode);
            file_r     <= in_file_id;
            srv_r      <= in_server_id;
            now_r      <= in_now;
            idx_r      <= '0;
            t_r        <= t_in;
            found_r    <= 1'b0;
            best_neg_r <= 1'b0;
            best_mag_r <= lfru_pkg::WEIGHT_BOUND;
            unique case (lfru_pkg::mode_t'(in_mode))
              lfru_pkg::MODE_ACCESS: state_r <= S_SCAN;
              lfru_pkg::MODE_RESET:  state_r <= S_CLR;
              lfru_pkg::MODE_ADD:    state_r <= S_SCAN;
              lfru_pkg::MODE_SELECT: begin
                alu_req_r <= '{go: 1'b1, op: lfru_pkg::ALU_MUL};
                alu_a_r   <= lfru_pkg::NUM_W'(t_in);
                alu_d_r   <= t_in;
                state_r   <= S_TT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_TT: begin
          if (alu_done) begin
            tt_r    <= alu_res[lfru_pkg::PROD_W-1:0];
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Add finishes here; the other modes stop at the fill count.
          if (mode_r == lfru_pkg::MODE_ADD) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_victim_r <= '0;
            if (used_r == lfru_pkg::USED_W'(lfru_pkg::TABLE_ENTRIES)) begin
              out_status_r <= lfru_pkg::ST_FULL;
            end else begin
              out_status_r <= lfru_pkg::ST_DONE;
              used_r       <= used_r + 1'b1;
            end
          end else if (scan_end) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            if (mode_r == lfru_pkg::MODE_SELECT) begin
              out_status_r <= found_r ? lfru_pkg::ST_DONE : lfru_pkg::ST_NO_VICTIM;
              out_victim_r <= found_r ? victim_r : '0;
            end else begin
              out_status_r <= lfru_pkg::ST_NO_MATCH;
              out_victim_r <= '0;
            end
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (mode_r == lfru_pkg::MODE_ACCESS) begin
            if (hit) begin
              state_r      <= S_IDLE;
              out_valid_r  <= 1'b1;
              out_status_r <= lfru_pkg::ST_DONE;
              out_victim_r <= '0;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_SCAN;
            end
          end else if (rd_server == srv_r) begin
            alu_req_r <= '{go: 1'b1, op: lfru_pkg::ALU_DIV};
            alu_a_r   <= lfru_pkg::NUM_W'(tt_r);
            alu_d_r   <= lfru_pkg::TIME_W'(c_eff);
            state_r   <= S_FREQ;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_FREQ: begin
          if (alu_done) begin
            freq_r    <= alu_res;
            alu_req_r <= '{go: 1'b1, op: lfru_pkg::ALU_MUL};
            alu_a_r   <= lfru_pkg::NUM_W'(pt_diff);
            alu_d_r   <= r_val;
            state_r   <= S_REC;
          end
        end
        S_REC: begin
          if (alu_done) begin
            neg_r     <= num_neg;
            alu_req_r <= '{go: 1'b1, op: lfru_pkg::ALU_DIV};
            alu_a_r   <= num_val;
            alu_d_r   <= p_eff;
            state_r   <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (alu_done) begin
            if (w_less) begin
              best_neg_r <= w_neg;
              best_mag_r <= alu_res;
              victim_r   <= rd_file;
              found_r    <= 1'b1;
            end
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_CLR: begin
          if (scan_end) begin
            pstart_r     <= now_r;
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= lfru_pkg::ST_DONE;
            out_victim_r <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_victim_file = out_victim_r;

  // A result is only given as the sequencer returns to idle.
  `LFRU_CHK(a_result_idle, out_valid |-> !busy, "result strobe while busy")
  // Every accepted request makes the sequencer busy in the next cycle.
  `LFRU_CHK(a_accept_busy, start && !busy |=> busy, "accepted request did not start")
  // Only a successful select names a file.
  `LFRU_CHK(a_victim_zero,
    out_valid && out_status != lfru_pkg::ST_DONE |-> out_victim_file == '0,
    "victim file on a failed request")
  // The fill count never passes the table size.
  `LFRU_CHK(a_used_range,
    used_r <= lfru_pkg::USED_W'(lfru_pkg::TABLE_ENTRIES), "fill count overflow")
  // No result strobe follows a reset edge.
  `LFRU_CHK_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe after reset")

endmodule
